>>> hdl/gcrf_pkg.sv
package gcrf_pkg;

  localparam int DEF_CORDIC_STAGES = 24;
  localparam int MAX_CORDIC_STAGES = 32;
  localparam int SQRT_STEPS = 31;

  localparam logic [1:0] REG_QUERY_LAT = 2'd0;
  localparam logic [1:0] REG_QUERY_LON = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [32:0] RECIP_45 = 33'd6108397932;
  localparam logic [57:0] DIST_SCALE = 58'd11066657;
  localparam logic [57:0] DIST_ROUND = 58'd2147483648;
  localparam logic [21:0] DIST_MAX = 22'd2764800;

  typedef struct packed {
    logic [3:0] sgn;
    logic [3:0][37:0] n;
    logic [3:0][32:0] est;
    logic [3:0] neg;
    logic [3:0][33:0] x;
    logic [3:0][33:0] y;
    logic [3:0][33:0] z;
    logic [33:0] sa2;
    logic [33:0] sb2;
    logic [33:0] p;
    logic [61:0] vh;
    logic [61:0] vc;
    logic [61:0] rh;
    logic [61:0] rc;
    logic [24:0] raw;
    logic [15:0] tag;
  } stage_t;

  typedef struct packed {
    logic hit;
    logic [21:0] dval;
    logic [15:0] tag;
  } res_t;

  function automatic logic [33:0] atan_bam(input logic [4:0] i);
    logic [33:0] a;
    case (i)
      5'd0: a = 34'd536870912;
      5'd1: a = 34'd316933406;
      5'd2: a = 34'd167458907;
      5'd3: a = 34'd85004756;
      5'd4: a = 34'd42667331;
      5'd5: a = 34'd21354465;
      5'd6: a = 34'd10679838;
      5'd7: a = 34'd5340245;
      5'd8: a = 34'd2670163;
      5'd9: a = 34'd1335087;
      5'd10: a = 34'd667544;
      5'd11: a = 34'd333772;
      5'd12: a = 34'd166886;
      5'd13: a = 34'd83443;
      5'd14: a = 34'd41722;
      5'd15: a = 34'd20861;
      5'd16: a = 34'd10430;
      5'd17: a = 34'd5215;
      5'd18: a = 34'd2608;
      5'd19: a = 34'd1304;
      5'd20: a = 34'd652;
      5'd21: a = 34'd326;
      5'd22: a = 34'd163;
      5'd23: a = 34'd81;
      5'd24: a = 34'd41;
      5'd25: a = 34'd20;
      5'd26: a = 34'd10;
      5'd27: a = 34'd5;
      5'd28: a = 34'd3;
      5'd29: a = 34'd1;
      5'd30: a = 34'd1;
      default: a = 34'd0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/great_circle_radius_filter.sv
// channel  | handshake            | payload
// rec      | rec_valid/rec_stall  | rec_lat, rec_lon, rec_tag
// res      | res_valid/res_stall  | within_res, distance, out_tag
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while rec_stall is low; res_valid rises once an accepted item has
// passed the two CORDIC chains, the 31-step square root pipeline and the output queue.
// Reset (rst, synchronous) clears valid bits, queue count and the configuration registers.
// A two-entry output queue absorbs res_stall; rec_stall rises only when it is full.
module great_circle_radius_filter #(
  parameter int CORDIC_STAGES = gcrf_pkg::DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  output logic        rec_stall,
  input  logic [30:0] rec_lat,
  input  logic [31:0] rec_lon,
  input  logic [15:0] rec_tag,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        within_res,
  output logic [21:0] distance,
  output logic [15:0] out_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N = (CORDIC_STAGES > gcrf_pkg::MAX_CORDIC_STAGES) ?
                     gcrf_pkg::MAX_CORDIC_STAGES : CORDIC_STAGES;
  localparam int J_ROT0 = 3;
  localparam int J_MUL = 3 + N;
  localparam int J_H = 4 + N;
  localparam int J_SQ0 = 5 + N;
  localparam int J_VEC0 = J_SQ0 + gcrf_pkg::SQRT_STEPS;
  localparam int J_RAW = J_VEC0 + N;
  localparam int L = J_RAW + 1;

  logic [30:0] query_lat;
  logic [31:0] query_lon;
  logic [21:0] radius;

  logic [L-1:0] v;
  gcrf_pkg::stage_t pl [L];
  logic advance;
  logic push;
  logic pop;
  logic [1:0] cnt;
  gcrf_pkg::res_t q0;
  gcrf_pkg::res_t q1;
  gcrf_pkg::res_t res_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_lat <= '0;
      query_lon <= '0;
      radius <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gcrf_pkg::REG_QUERY_LAT: query_lat <= cfg_data[30:0];
        gcrf_pkg::REG_QUERY_LON: query_lon <= cfg_data;
        gcrf_pkg::REG_RADIUS: radius <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  assign advance = (cnt != 2'd2);
  assign rec_stall = !advance;
  assign push = advance && v[L-1];
  assign res_valid = (cnt != 2'd0);
  assign pop = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[L-2:0], rec_valid};
    end
  end

  genvar j;
  generate
    for (j = 0; j < L; j++) begin : g_st
      gcrf_pkg::stage_t d;

      if (j == 0) begin : g_prep
        always_comb begin
          logic [3:0][33:0] a;
          logic [33:0] av;
          d = '0;
          a[0] = {{3{query_lat[30]}}, query_lat} - {{3{rec_lat[30]}}, rec_lat};
          a[1] = {{2{query_lon[31]}}, query_lon} - {{2{rec_lon[31]}}, rec_lon};
          a[2] = {{3{rec_lat[30]}}, rec_lat};
          a[3] = {{3{query_lat[30]}}, query_lat};
          for (int k = 0; k < 4; k++) begin
            d.sgn[k] = a[k][33];
            av = a[k][33] ? -a[k] : a[k];
            if (k < 2) begin
              d.n[k] = {av[32:0], 5'b0} + 38'd22;
            end else begin
              d.n[k] = {av[31:0], 6'b0} + 38'd22;
            end
          end
          d.tag = rec_tag;
        end
      end else if (j == 1) begin : g_mul45
        always_comb begin
          logic [70:0] prod;
          d = pl[j-1];
          for (int k = 0; k < 4; k++) begin
            prod = {33'b0, pl[j-1].n[k]} * {38'b0, gcrf_pkg::RECIP_45};
            d.est[k] = prod[70:38];
          end
        end
      end else if (j == 2) begin : g_fold
        always_comb begin
          logic [37:0] r;
          logic [32:0] q;
          logic [31:0] a;
          d = pl[j-1];
          for (int k = 0; k < 4; k++) begin
            r = pl[j-1].n[k] - {5'b0, pl[j-1].est[k]} * 38'd45;
            q = pl[j-1].est[k] + {32'b0, (r >= 38'd45)};
            a = pl[j-1].sgn[k] ? -q[31:0] : q[31:0];
            d.neg[k] = (a >= 32'h4000_0000) && (a < 32'hC000_0000);
            if (d.neg[k]) begin
              a = a - 32'h8000_0000;
            end
            d.z[k] = {{2{a[31]}}, a};
            d.x[k] = gcrf_pkg::CORDIC_GAIN;
            d.y[k] = '0;
          end
        end
      end else if (j < J_MUL) begin : g_rot
        localparam int I = j - J_ROT0;
        always_comb begin
          logic signed [33:0] xs, ys, zs, dx, dy, at;
          d = pl[j-1];
          at = $signed(gcrf_pkg::atan_bam(5'(I)));
          for (int k = 0; k < 4; k++) begin
            xs = $signed(pl[j-1].x[k]);
            ys = $signed(pl[j-1].y[k]);
            zs = $signed(pl[j-1].z[k]);
            dx = ys >>> I;
            dy = xs >>> I;
            if (!zs[33]) begin
              xs = xs - dx;
              ys = ys + dy;
              zs = zs - at;
            end else begin
              xs = xs + dx;
              ys = ys - dy;
              zs = zs + at;
            end
            d.x[k] = xs;
            d.y[k] = ys;
            d.z[k] = zs;
          end
        end
      end else if (j == J_MUL) begin : g_sq
        always_comb begin
          logic signed [33:0] sa, sb, c1, c2;
          logic signed [67:0] pa, pb, pc;
          d = pl[j-1];
          sa = $signed(pl[j-1].y[0]);
          sb = $signed(pl[j-1].y[1]);
          c1 = $signed(pl[j-1].x[2]);
          c2 = $signed(pl[j-1].x[3]);
          pa = sa * sa;
          pb = sb * sb;
          pc = c1 * c2;
          if (pl[j-1].neg[2] ^ pl[j-1].neg[3]) begin
            pc = -pc;
          end
          d.sa2 = pa[63:30];
          d.sb2 = pb[63:30];
          d.p = pc[63:30];
        end
      end else if (j == J_H) begin : g_hav
        always_comb begin
          logic signed [68:0] pr;
          logic signed [39:0] h;
          logic [30:0] hc;
          d = pl[j-1];
          pr = $signed(pl[j-1].p) * $signed({1'b0, pl[j-1].sb2});
          h = $signed({6'b0, pl[j-1].sa2}) + $signed({pr[68], pr[68:30]});
          if (h[39]) begin
            hc = '0;
          end else if (h > 40'sd1073741824) begin
            hc = 31'd1073741824;
          end else begin
            hc = h[30:0];
          end
          d.vh = {1'b0, hc, 30'b0};
          d.vc = {1'b0, 31'd1073741824 - hc, 30'b0};
          d.rh = '0;
          d.rc = '0;
        end
      end else if (j < J_VEC0) begin : g_sqrt
        localparam int T = j - J_SQ0;
        localparam logic [61:0] BIT = 62'(1) << (60 - 2 * T);
        always_comb begin
          logic [61:0] sh, sc;
          d = pl[j-1];
          sh = pl[j-1].rh + BIT;
          sc = pl[j-1].rc + BIT;
          if (pl[j-1].vh >= sh) begin
            d.vh = pl[j-1].vh - sh;
            d.rh = (pl[j-1].rh >> 1) + BIT;
          end else begin
            d.rh = pl[j-1].rh >> 1;
          end
          if (pl[j-1].vc >= sc) begin
            d.vc = pl[j-1].vc - sc;
            d.rc = (pl[j-1].rc >> 1) + BIT;
          end else begin
            d.rc = pl[j-1].rc >> 1;
          end
        end
      end else if (j < J_RAW) begin : g_vec
        localparam int I = j - J_VEC0;
        always_comb begin
          logic signed [33:0] xs, ys, zs, dx, dy, at;
          d = pl[j-1];
          at = $signed(gcrf_pkg::atan_bam(5'(I)));
          if (I == 0) begin
            xs = $signed(pl[j-1].rc[33:0]);
            ys = $signed(pl[j-1].rh[33:0]);
            zs = '0;
          end else begin
            xs = $signed(pl[j-1].x[0]);
            ys = $signed(pl[j-1].y[0]);
            zs = $signed(pl[j-1].z[0]);
          end
          dx = ys >>> I;
          dy = xs >>> I;
          if (!ys[33]) begin
            xs = xs + dx;
            ys = ys - dy;
            zs = zs + at;
          end else begin
            xs = xs - dx;
            ys = ys + dy;
            zs = zs - at;
          end
          d.x[0] = xs;
          d.y[0] = ys;
          d.z[0] = zs;
        end
      end else begin : g_raw
        always_comb begin
          logic [32:0] th;
          logic [57:0] sum;
          d = pl[j-1];
          th = pl[j-1].z[0][33] ? 33'd0 : pl[j-1].z[0][32:0];
          sum = {25'b0, th} * gcrf_pkg::DIST_SCALE + gcrf_pkg::DIST_ROUND;
          d.raw = sum[56:32];
        end
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          pl[j] <= d;
        end
      end
    end
  endgenerate

  always_comb begin
    res_in.hit = (pl[L-1].raw <= {3'b0, radius});
    res_in.dval = (pl[L-1].raw > {3'b0, gcrf_pkg::DIST_MAX}) ?
                  gcrf_pkg::DIST_MAX : pl[L-1].raw[21:0];
    res_in.tag = pl[L-1].tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
    if (push && pop) begin
      if (cnt == 2'd2) begin
        q0 <= q1;
        q1 <= res_in;
      end else begin
        q0 <= res_in;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        q0 <= res_in;
      end else begin
        q1 <= res_in;
      end
    end
  end

  assign within_res = q0.hit;
  assign distance = q0.dval;
  assign out_tag = q0.tag;

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue overfilled");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && cnt == 2'd1) |=> !res_valid)
    else $error("output queue did not drain");
  a_travel: assert property (@(posedge clk) disable iff (rst)
    (advance && v[0]) |=> v[1])
    else $error("item lost between stages");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> distance <= gcrf_pkg::DIST_MAX)
    else $error("distance above saturation");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef longint unsigned u64_t;

  localparam int STAGES = gcrf_pkg::DEF_CORDIC_STAGES;
  localparam int LATENCY = 37 + 2 * STAGES + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint GAIN = 64'd652032874;
  localparam longint SCALE = 64'd11066657;
  localparam longint MAXDIST = 64'd2764800;
  localparam longint ONE_Q30 = 64'd1 << 30;
  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rec_valid = 1'b0;
  logic rec_stall;
  logic [30:0] rec_lat = '0;
  logic [31:0] rec_lon = '0;
  logic [15:0] rec_tag = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic within_res;
  logic [21:0] distance;
  logic [15:0] out_tag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors = 0;
  int idle_cycles = 0;

  great_circle_radius_filter #(.CORDIC_STAGES(STAGES)) uut (.*);

  always #10 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint atan_step(input int i);
    return longint'(gcrf_pkg::atan_bam(5'(i)));
  endfunction

  function automatic logic [31:0] bin_angle(input longint v, input longint num);
    longint p, q;
    p = v * num;
    q = (p >= 0) ? (p + 22) / 45 : (p - 22) / 45;
    return q[31:0];
  endfunction

  function automatic void rotate(input logic [31:0] a, output longint s, output longint c);
    bit flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = GAIN;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  class distance_scoreboard;
    longint q_lat, q_lon, q_radius;
    gcrf_pkg::res_t pending[$];

    function void set_reg(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
        gcrf_pkg::REG_QUERY_LAT: q_lat = longint'($signed(v[30:0]));
        gcrf_pkg::REG_QUERY_LON: q_lon = longint'($signed(v));
        gcrf_pkg::REG_RADIUS: q_radius = longint'(v[21:0]);
        default: ;
      endcase
    endfunction

    function void note_record(input logic [30:0] la, input logic [31:0] lo,
                              input logic [15:0] tg);
      longint rl, rn, sa, ca, sb, cb, s1, c1, s2, c2, sa2, sb2, p, h, th;
      longint unsigned raw;
      gcrf_pkg::res_t r;
      rl = longint'($signed(la));
      rn = longint'($signed(lo));
      rotate(bin_angle(q_lat - rl, 32), sa, ca);
      rotate(bin_angle(q_lon - rn, 32), sb, cb);
      rotate(bin_angle(rl, 64), s1, c1);
      rotate(bin_angle(q_lat, 64), s2, c2);
      sa2 = longint'((u64_t'(sa * sa)) >> 30);
      sb2 = longint'((u64_t'(sb * sb)) >> 30);
      p = (c1 * c2) >>> 30;
      h = sa2 + ((p * sb2) >>> 30);
      if (h < 0) h = 0;
      if (h > ONE_Q30) h = ONE_Q30;
      th = vector_angle(floor_sqrt(u64_t'(h) << 30),
                        floor_sqrt(u64_t'(ONE_Q30 - h) << 30));
      if (th < 0) th = 0;
      raw = (u64_t'(th) * u64_t'(SCALE) + (64'd1 << 31)) >> 32;
      r.hit = (raw <= u64_t'(q_radius));
      r.dval = (raw > u64_t'(MAXDIST)) ? 22'(MAXDIST) : raw[21:0];
      r.tag = tg;
      pending = {pending, r};
    endfunction

    task check_result(input logic w, input logic [21:0] d, input logic [15:0] tg);
      gcrf_pkg::res_t e;
      if (pending.size() == 0) begin
        report("unexpected result, tag", longint'(tg), -1);
        return;
      end
      e = pending.pop_front();
      if (w !== e.hit) report("within_res", longint'(w), longint'(e.hit));
      if (d !== e.dval) report("distance", longint'(d), longint'(e.dval));
      if (tg !== e.tag) report("out_tag", longint'(tg), longint'(e.tag));
    endtask
  endclass

  distance_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (rec_valid && !rec_stall) sb.note_record(rec_lat, rec_lon, rec_tag);
      if (res_valid && !res_stall) sb.check_result(within_res, distance, out_tag);
      if ((rec_valid && !rec_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  bit stall_free = 1'b0;

  initial begin : sink
    int w;
    @(negedge rst);
    forever begin
      w = stall_free ? 0 : $urandom_range(0, 6);
      if (w != 0) begin
        res_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic send_record(input longint la, input longint lo, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 6) : 0;
    if (w != 0) begin
      rec_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    rec_valid <= 1'b1;
    rec_lat <= la[30:0];
    rec_lon <= lo[31:0];
    rec_tag <= 16'($urandom);
    @(posedge clk);
    while (rec_stall) @(posedge clk);
  endtask

  function automatic longint rand_span(input longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic longint rand_near(input longint c, input longint lim);
    longint v;
    v = c + longint'($urandom_range(0, 200000000)) - 100000000;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  initial begin
    longint la, lo;
    longint corner[3] = '{-1, 0, 1};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(gcrf_pkg::REG_QUERY_LAT, 32'd0);
    write_reg(gcrf_pkg::REG_QUERY_LON, 32'd0);
    write_reg(gcrf_pkg::REG_RADIUS, 32'd2764800);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    foreach (corner[i]) foreach (corner[j])
      send_record(corner[i] * LAT_MAX, corner[j] * LON_MAX, 1'b0);
    send_record(0, 0, 1'b0);
    send_record(-(64'd1 << 30), -(64'd1 << 31), 1'b0);
    send_record((64'd1 << 30) - 1, (64'd1 << 31) - 1, 1'b0);
    send_record(1, -1, 1'b0);
    send_record(LAT_MAX, 0, 1'b1);
    rec_valid <= 1'b0;
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(gcrf_pkg::REG_QUERY_LAT, 32'(-LAT_MAX));
          write_reg(gcrf_pkg::REG_QUERY_LON, 32'(LON_MAX));
          write_reg(gcrf_pkg::REG_RADIUS, 32'd0);
        end
        1: begin
          write_reg(gcrf_pkg::REG_QUERY_LAT, 32'(LAT_MAX));
          write_reg(gcrf_pkg::REG_QUERY_LON, 32'(-LON_MAX));
          write_reg(gcrf_pkg::REG_RADIUS, 32'h3F_FFFF);
        end
        default: begin
          write_reg(gcrf_pkg::REG_QUERY_LAT, 32'(rand_span(LAT_MAX)));
          write_reg(gcrf_pkg::REG_QUERY_LON, 32'(rand_span(LON_MAX)));
          write_reg(gcrf_pkg::REG_RADIUS, 32'($urandom_range(0, 100000)));
        end
      endcase
      stall_free = (ph == 3);
      for (int n = 0; n < 200; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            la = longint'($signed(31'($urandom)));
            lo = longint'($signed(32'($urandom)));
          end
          1, 2, 3: begin
            la = rand_near(sb.q_lat, LAT_MAX);
            lo = rand_near(sb.q_lon, LON_MAX);
          end
          default: begin
            la = rand_span(LAT_MAX);
            lo = rand_span(LON_MAX);
          end
        endcase
        send_record(la, lo, (ph != 3) && (n % 50 < 40));
      end
      rec_valid <= 1'b0;
      settle();
    end

    if (errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
